@@ sv/cdf_pkg.sv @@
// ----------------------------------------------------------------------------
// cdf_pkg
// types, constants and the byte-wide crc update shared by the deframer files
// ----------------------------------------------------------------------------
package cdf_pkg;

    localparam logic [31:0] CRC_POLY      = 32'h1edc6f41;
    localparam int          HEADER_BYTES  = 8;
    localparam int          TRAILER_BYTES = 4;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TRAILER = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TRAILER = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [31:0] id;
        logic [31:0] size;
        logic        header_done;
        logic        payload_last;
        logic        chunk_done;
        logic        crc_mismatch;
        logic        error_seen;
    } t_result;

    // msb-first crc over one byte, eight shift/xor steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] x;
        x = crc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++) begin
            if (x[31]) begin
                x = {x[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                x = {x[30:0], 1'b0};
            end
        end
        return x;
    endfunction

endpackage

@@ sv/chunk_deframer_crc32c_check_unit.sv @@
// ----------------------------------------------------------------------------
// chunk_deframer_crc32c_check_unit
// splits a byte stream into id/size/payload/crc chunks and, with crc enabled, checks each crc
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_data_byte
//  result    out        o_valid / i_stall    o_byte_kind .. o_error_seen
//  config    in         i_cfg_we             i_cfg_data (crc_enable)
//
//  one byte per cycle while the result register has room, one result per byte; the result is registered
//  the parser state and the byte-wide crc xor network update in the accept cycle
//  the result register frees in the same cycle the consumer takes its transfer
//  i_rst_n is synchronous: header phase, crc and sticky error cleared, crc on
//  a stalled result holds o_stall high until the consumer takes it
// ----------------------------------------------------------------------------
module chunk_deframer_crc32c_check_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    // results
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_byte_kind,
    output logic [7:0]  o_byte_out,
    output logic [31:0] o_chunk_id,
    output logic [31:0] o_chunk_size,
    output logic        o_header_done,
    output logic        o_payload_last,
    output logic        o_chunk_done,
    output logic        o_crc_mismatch,
    output logic        o_error_seen
);
    import cdf_pkg::*;

    logic    fire;
    logic    busy;
    t_result step_res;
    t_result out_res;

    // a byte transfer happens whenever a byte is offered and the result register has room
    assign o_stall = busy;
    assign fire    = i_valid && !busy;

    // parser: state registers plus next-state and result logic
    cdf_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_byte     (i_data_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_res      (step_res)
    );

    // result register decouples the consumer's stall from the parser
    cdf_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (step_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_busy  (busy),
        .o_res   (out_res)
    );

    // unpack result fields onto ports
    assign o_byte_kind    = out_res.kind;
    assign o_byte_out     = out_res.data;
    assign o_chunk_id     = out_res.id;
    assign o_chunk_size   = out_res.size;
    assign o_header_done  = out_res.header_done;
    assign o_payload_last = out_res.payload_last;
    assign o_chunk_done   = out_res.chunk_done;
    assign o_crc_mismatch = out_res.crc_mismatch;
    assign o_error_seen   = out_res.error_seen;

    a_mismatch_sets_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_crc_mismatch) |-> (o_error_seen && o_chunk_done))
        else $error("mismatch without error flag or chunk end");

    a_header_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_header_done) |-> (o_byte_kind == KIND_HEADER))
        else $error("header done on a non-header byte");

    a_payload_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_payload_last) |-> (o_byte_kind == KIND_PAYLOAD))
        else $error("payload last on a non-payload byte");

endmodule

@@ sv/cdf_step.sv @@
// ----------------------------------------------------------------------------
// cdf_step
// chunk parser state and the per-byte next-state and result logic
// ----------------------------------------------------------------------------
module cdf_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic             i_cfg_we,
    input  logic             i_cfg_data,
    output cdf_pkg::t_result o_res
);
    import cdf_pkg::*;

    localparam logic [2:0] IDX_ID_DONE  = 3'(HEADER_BYTES / 2);
    localparam logic [2:0] IDX_TRL_DONE = 3'(TRAILER_BYTES);

    t_phase      r_phase,     n_phase;
    logic [2:0]  r_idx,       n_idx;
    logic [31:0] r_asm,       n_asm;
    logic [31:0] r_id,        n_id;
    logic [31:0] r_size,      n_size;
    logic [31:0] r_remaining, n_remaining;
    logic [31:0] r_crc,       n_crc;
    logic        r_sticky,    n_sticky;
    logic        r_crc_en;

    logic [31:0] crc_upd;
    logic [31:0] crc_base;
    logic [31:0] asm_shift;
    logic [2:0]  idx_inc;
    t_kind       kind;
    logic        hdone, plast, cdone, mism;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_asm       = r_asm;
        n_id        = r_id;
        n_size      = r_size;
        n_remaining = r_remaining;
        n_crc       = r_crc;
        n_sticky    = r_sticky;
        kind        = KIND_HEADER;
        hdone       = 1'b0;
        plast       = 1'b0;
        cdone       = 1'b0;
        mism        = 1'b0;
        asm_shift   = {r_asm[23:0], i_byte};
        idx_inc     = r_idx + 3'd1;
        // crc restarts on the first header byte
        crc_base    = (r_phase != PH_PAYLOAD && r_phase != PH_TRAILER && r_idx == 3'd0)
                      ? 32'h0 : r_crc;
        crc_upd     = crc_byte(crc_base, i_byte);

        unique case (r_phase)
            PH_PAYLOAD: begin
                kind        = KIND_PAYLOAD;
                if (r_crc_en) begin
                    n_crc = crc_upd;
                end
                n_remaining = r_remaining - 32'd1;
                if (n_remaining == 32'd0) begin
                    plast = 1'b1;
                    n_idx = 3'd0;
                    n_asm = 32'h0;
                    if (r_crc_en) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        n_phase = PH_HEADER;
                        cdone   = 1'b1;
                    end
                end
            end
            PH_TRAILER: begin
                kind  = KIND_TRAILER;
                n_asm = asm_shift;
                n_idx = idx_inc;
                if (idx_inc == IDX_TRL_DONE) begin
                    cdone = 1'b1;
                    if (asm_shift != r_crc) begin
                        mism     = 1'b1;
                        n_sticky = 1'b1;
                    end
                    n_phase = PH_HEADER;
                    n_idx   = 3'd0;
                    n_asm   = 32'h0;
                end
            end
            default: begin
                // header, also the unused phase code
                kind    = KIND_HEADER;
                n_phase = PH_HEADER;
                if (r_crc_en) begin
                    n_crc = crc_upd;
                end
                n_asm = asm_shift;
                n_idx = idx_inc;
                if (idx_inc == IDX_ID_DONE) begin
                    n_id  = asm_shift;
                    n_asm = 32'h0;
                end else if (idx_inc == 3'd0) begin
                    hdone       = 1'b1;
                    n_size      = asm_shift;
                    n_remaining = asm_shift;
                    n_asm       = 32'h0;
                    if (asm_shift != 32'h0) begin
                        n_phase = PH_PAYLOAD;
                    end else if (r_crc_en) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        cdone = 1'b1;
                    end
                end
            end
        endcase

        o_res.kind         = kind;
        o_res.data         = i_byte;
        o_res.id           = n_id;
        o_res.size         = n_size;
        o_res.header_done  = hdone;
        o_res.payload_last = plast;
        o_res.chunk_done   = cdone;
        o_res.crc_mismatch = mism;
        o_res.error_seen   = n_sticky;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_idx       <= 3'd0;
            r_asm       <= 32'h0;
            r_id        <= 32'h0;
            r_size      <= 32'h0;
            r_remaining <= 32'h0;
            r_crc       <= 32'h0;
            r_sticky    <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_asm       <= n_asm;
            r_id        <= n_id;
            r_size      <= n_size;
            r_remaining <= n_remaining;
            r_crc       <= n_crc;
            r_sticky    <= n_sticky;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_crc_en <= i_cfg_data;
        end
    end

    a_payload_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_remaining != 32'h0)
        else $error("payload phase with zero bytes remaining");

    a_trailer_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TRAILER |-> r_idx < IDX_TRL_DONE)
        else $error("trailer byte index out of range");

    a_sticky_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sticky |=> r_sticky)
        else $error("sticky error cleared");

    a_mismatch_ends_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mism |-> (cdone && r_phase == PH_TRAILER))
        else $error("crc mismatch outside trailer end");

endmodule

@@ sv/cdf_out_reg.sv @@
// ----------------------------------------------------------------------------
// cdf_out_reg
// result register with valid/stall handshake toward the consumer
// ----------------------------------------------------------------------------
module cdf_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cdf_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_busy,
    output cdf_pkg::t_result o_res
);
    import cdf_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // register can take a new result when empty or being drained this cycle
    assign o_busy = r_valid && i_stall;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_stall) begin
            n_valid = r_valid;
        end else begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |-> !i_load)
        else $error("result overwritten while stalled");

endmodule
